// ===== hdl/pss_pkg.sv =====
// shared types and constants of the preemptive priority scheduler
// no dependencies; used by pss_cell and preemptive_priority_scheduler_core

package pss_pkg;

    // default sizing of the job table and the time count
    localparam int SLOTS_DEF     = 16;
    localparam int TIME_BITS_DEF = 16;

    // fixed field widths
    localparam int ID_W       = 6;
    localparam int BURST_W    = 8;
    localparam int PRIO_W     = 8;
    localparam int OUT_TIME_W = 16;

    // kind of walk the token makes along the row of cells
    typedef enum logic [1:0] {
        SCAN_FREE  = 2'd0,
        SCAN_BEST  = 2'd1,
        SCAN_FETCH = 2'd2
    } scan_op_t;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        scan_op_t               scan_op;
        logic                   wr_en;
        logic                   mark_en;
        logic                   step_en;
        logic [ID_W-1:0]        new_id;
        logic [BURST_W-1:0]     new_burst;
        logic [PRIO_W-1:0]      new_prio;
    } cell_ctl_t;

    // fixed-width part of the token handed from cell to cell
    typedef struct packed {
        logic                   found;
        logic                   has_run;
        logic [PRIO_W-1:0]      prio;
        logic [ID_W-1:0]        job_id;
        logic [BURST_W-1:0]     remaining;
        logic [BURST_W-1:0]     orig_burst;
    } tok_t;

endpackage

// ===== hdl/pss_cell.sv =====
// one slot of the job table with its stage of the scan token chain
// depends on pss_pkg

module pss_cell #(
    parameter int SLOTS     = pss_pkg::SLOTS_DEF,
    parameter int TIME_BITS = pss_pkg::TIME_BITS_DEF,
    parameter int INDEX     = 0,
    localparam int SlotW    = $clog2(SLOTS)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pss_pkg::cell_ctl_t     ctl,
    input  logic [SlotW-1:0]       wr_slot,
    input  logic [SlotW-1:0]       act_slot,
    input  logic [TIME_BITS-1:0]   time_count,
    input  pss_pkg::tok_t          tok_in,
    input  logic [SlotW-1:0]       tok_in_slot,
    input  logic [TIME_BITS-1:0]   tok_in_age,
    output pss_pkg::tok_t          tok_out,
    output logic [SlotW-1:0]       tok_out_slot,
    output logic [TIME_BITS-1:0]   tok_out_age,
    output logic                   occupied
);

    localparam int KeyW = pss_pkg::PRIO_W + 1 + TIME_BITS + pss_pkg::ID_W;

    logic                          valid_reg;
    logic                          valid_next;
    logic [pss_pkg::ID_W-1:0]      job_id_reg;
    logic [pss_pkg::BURST_W-1:0]   remaining_reg;
    logic [pss_pkg::BURST_W-1:0]   remaining_next;
    logic [pss_pkg::BURST_W-1:0]   orig_burst_reg;
    logic [pss_pkg::PRIO_W-1:0]    prio_reg;
    logic [TIME_BITS-1:0]          stamp_reg;
    logic                          has_run_reg;
    logic                          has_run_next;

    pss_pkg::tok_t                 tok_reg;
    pss_pkg::tok_t                 tok_next;
    logic [SlotW-1:0]              tok_slot_reg;
    logic [SlotW-1:0]              tok_slot_next;
    logic [TIME_BITS-1:0]          tok_age_reg;
    logic [TIME_BITS-1:0]          tok_age_next;

    logic [TIME_BITS-1:0]          age_self;
    logic [KeyW-1:0]               key_self;
    logic [KeyW-1:0]               key_tok;
    logic                          take;
    logic                          wr_hit;
    logic                          act_hit;

    // ordering key: lower is better; an older stamp gives a larger age
    assign age_self = time_count - stamp_reg;
    assign key_self = {prio_reg, has_run_reg, ~age_self, job_id_reg};
    assign key_tok  = {tok_in.prio, tok_in.has_run, ~tok_in_age, tok_in.job_id};

    // does this slot replace the token it receives
    always_comb
    begin
        case (ctl.scan_op)
            pss_pkg::SCAN_FREE:  take = !valid_reg && !tok_in.found;
            pss_pkg::SCAN_BEST:  take = valid_reg && (!tok_in.found || key_self < key_tok);
            pss_pkg::SCAN_FETCH: take = valid_reg && (act_slot == SlotW'(INDEX));
            default:             take = 1'b0;
        endcase
    end

    // token handed to the next cell
    always_comb
    begin
        tok_next      = tok_in;
        tok_slot_next = tok_in_slot;
        tok_age_next  = tok_in_age;
        if (take)
        begin
            tok_next.found      = 1'b1;
            tok_next.has_run    = has_run_reg;
            tok_next.prio       = prio_reg;
            tok_next.job_id     = job_id_reg;
            tok_next.remaining  = remaining_reg;
            tok_next.orig_burst = orig_burst_reg;
            tok_slot_next       = SlotW'(INDEX);
            tok_age_next        = age_self;
        end
    end

    // slot updates: new job, preemption mark, one unit of service
    assign wr_hit  = ctl.wr_en && (wr_slot == SlotW'(INDEX));
    assign act_hit = act_slot == SlotW'(INDEX);

    always_comb
    begin
        valid_next     = valid_reg;
        has_run_next   = has_run_reg;
        remaining_next = remaining_reg;
        if (wr_hit)
        begin
            valid_next     = 1'b1;
            has_run_next   = 1'b0;
            remaining_next = ctl.new_burst;
        end
        else if (act_hit && (ctl.mark_en || ctl.step_en))
        begin
            has_run_next = 1'b1;
            if (ctl.step_en)
            begin
                if (remaining_reg > pss_pkg::BURST_W'(1))
                begin
                    remaining_next = remaining_reg - pss_pkg::BURST_W'(1);
                end
                else
                begin
                    remaining_next = '0;
                    valid_next     = 1'b0;
                end
            end
        end
    end

    // occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // slot contents and token stage
    always_ff @(posedge clk)
    begin
        has_run_reg   <= has_run_next;
        remaining_reg <= remaining_next;
        if (wr_hit)
        begin
            job_id_reg     <= ctl.new_id;
            orig_burst_reg <= ctl.new_burst;
            prio_reg       <= ctl.new_prio;
            stamp_reg      <= time_count;
        end
        tok_reg      <= tok_next;
        tok_slot_reg <= tok_slot_next;
        tok_age_reg  <= tok_age_next;
    end

    assign tok_out      = tok_reg;
    assign tok_out_slot = tok_slot_reg;
    assign tok_out_age  = tok_age_reg;
    assign occupied     = valid_reg;

endmodule

// ===== hdl/preemptive_priority_scheduler_core.sv =====
// top level of the preemptive priority scheduler: sequencer, time count and result register
// depends on pss_pkg and pss_cell
// an item is accepted only in idle; its scan token then walks the row of slot cells one cell per cycle,
// and any result is registered in the exec state, which holds while a result is due and the result register is stalled;
// a new item is not taken until the last one has left the exec state
// reset: table empty, time count zero, no job running; no clearing pass

module preemptive_priority_scheduler_core #(
    parameter int SLOTS     = pss_pkg::SLOTS_DEF,
    parameter int TIME_BITS = pss_pkg::TIME_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    output logic                             cmd_stall,
    input  logic                             command,
    input  logic [pss_pkg::ID_W-1:0]         proc_id,
    input  logic [pss_pkg::BURST_W-1:0]      burst_length,
    input  logic [pss_pkg::PRIO_W-1:0]       priority_level,
    output logic                             res_valid,
    input  logic                             res_stall,
    output logic [pss_pkg::ID_W-1:0]         ran_id,
    output logic                             idle,
    output logic                             finished,
    output logic [pss_pkg::OUT_TIME_W-1:0]   turnaround,
    output logic [pss_pkg::OUT_TIME_W-1:0]   waiting,
    output logic                             rejected
);

    localparam int SlotW = $clog2(SLOTS);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_EXEC = 3'b100
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic [SlotW-1:0]                cnt_reg;
    logic [SlotW-1:0]                cnt_next;
    pss_pkg::scan_op_t               scan_op_reg;
    logic                            tick_reg;
    logic [pss_pkg::ID_W-1:0]        new_id_reg;
    logic [pss_pkg::BURST_W-1:0]     new_burst_reg;
    logic [pss_pkg::PRIO_W-1:0]      new_prio_reg;
    logic [TIME_BITS-1:0]            time_count_reg;
    logic [SlotW-1:0]                running_slot_reg;
    logic                            running_valid_reg;
    logic [pss_pkg::PRIO_W-1:0]      running_prio_reg;

    logic                            res_valid_reg;
    logic [pss_pkg::ID_W-1:0]        ran_id_reg;
    logic                            idle_reg;
    logic                            finished_reg;
    logic [pss_pkg::OUT_TIME_W-1:0]  turnaround_reg;
    logic [pss_pkg::OUT_TIME_W-1:0]  waiting_reg;
    logic                            rejected_reg;

    pss_pkg::tok_t                   tok [SLOTS+1];
    logic [SlotW-1:0]                tok_slot [SLOTS+1];
    logic [TIME_BITS-1:0]            tok_age [SLOTS+1];
    logic [SLOTS-1:0]                occ;

    pss_pkg::cell_ctl_t              ctl;
    logic [SlotW-1:0]                act_slot;
    pss_pkg::tok_t                   last;
    logic [SlotW-1:0]                last_slot;
    logic                            cmd_take;
    logic                            in_exec;
    logic                            need_out;
    logic                            exec_go;
    logic                            job_done;
    logic                            preempt;
    logic [TIME_BITS-1:0]            ta_full;
    logic [TIME_BITS-1:0]            wt_full;

    // input handshake: one item at a time
    assign cmd_stall = (state_reg != S_IDLE);
    assign cmd_take  = cmd_valid && !cmd_stall;

    // token coming out of the last cell
    assign last      = tok[SLOTS];
    assign last_slot = tok_slot[SLOTS];
    assign in_exec   = (state_reg == S_EXEC);
    assign need_out  = tick_reg || !last.found;
    assign exec_go   = in_exec && (!need_out || !res_valid_reg || !res_stall);
    assign job_done  = last.remaining <= pss_pkg::BURST_W'(1);
    assign preempt   = running_valid_reg && (new_prio_reg < running_prio_reg);

    // times of a finishing job
    assign ta_full = tok_age[SLOTS] + TIME_BITS'(1);
    assign wt_full = ta_full - TIME_BITS'(last.orig_burst);

    // control broadcast to the cells
    always_comb
    begin
        ctl.scan_op   = scan_op_reg;
        ctl.wr_en     = exec_go && !tick_reg && last.found;
        ctl.mark_en   = exec_go && !tick_reg && last.found && preempt;
        ctl.step_en   = exec_go && tick_reg && last.found;
        ctl.new_id    = new_id_reg;
        ctl.new_burst = new_burst_reg;
        ctl.new_prio  = new_prio_reg;
    end

    assign act_slot = (in_exec && tick_reg) ? last_slot : running_slot_reg;

    // empty token enters the first cell
    assign tok[0]      = '0;
    assign tok_slot[0] = '0;
    assign tok_age[0]  = '0;

    // row of slot cells
    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        pss_cell #(
            .SLOTS     (SLOTS),
            .TIME_BITS (TIME_BITS),
            .INDEX     (g)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctl          (ctl),
            .wr_slot      (last_slot),
            .act_slot     (act_slot),
            .time_count   (time_count_reg),
            .tok_in       (tok[g]),
            .tok_in_slot  (tok_slot[g]),
            .tok_in_age   (tok_age[g]),
            .tok_out      (tok[g+1]),
            .tok_out_slot (tok_slot[g+1]),
            .tok_out_age  (tok_age[g+1]),
            .occupied     (occ[g])
        );
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (cmd_take)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cnt_next = cnt_reg + SlotW'(1);
                if (cnt_reg == SlotW'(SLOTS - 1))
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            cnt_reg           <= '0;
            scan_op_reg       <= pss_pkg::SCAN_FREE;
            tick_reg          <= 1'b0;
            time_count_reg    <= '0;
            running_slot_reg  <= '0;
            running_valid_reg <= 1'b0;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            // choose the walk for the accepted item
            if (cmd_take)
            begin
                tick_reg <= command;
                if (!command)
                begin
                    scan_op_reg <= pss_pkg::SCAN_FREE;
                end
                else if (running_valid_reg)
                begin
                    scan_op_reg <= pss_pkg::SCAN_FETCH;
                end
                else
                begin
                    scan_op_reg <= pss_pkg::SCAN_BEST;
                end
            end
            // running job and time count
            if (exec_go)
            begin
                if (tick_reg)
                begin
                    time_count_reg <= time_count_reg + TIME_BITS'(1);
                    if (last.found)
                    begin
                        running_slot_reg  <= last_slot;
                        running_valid_reg <= !job_done;
                    end
                end
                else if (last.found && preempt)
                begin
                    running_slot_reg <= last_slot;
                end
            end
            // result register occupancy
            if (exec_go && need_out)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // item payload, running priority and result payload
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            new_id_reg    <= proc_id;
            new_burst_reg <= burst_length;
            new_prio_reg  <= priority_level;
        end
        if (exec_go)
        begin
            if (tick_reg && last.found)
            begin
                running_prio_reg <= last.prio;
            end
            else if (!tick_reg && last.found && preempt)
            begin
                running_prio_reg <= new_prio_reg;
            end
        end
        if (exec_go && need_out)
        begin
            ran_id_reg     <= '0;
            idle_reg       <= 1'b0;
            finished_reg   <= 1'b0;
            turnaround_reg <= '0;
            waiting_reg    <= '0;
            rejected_reg   <= 1'b0;
            if (!tick_reg)
            begin
                rejected_reg <= 1'b1;
            end
            else if (!last.found)
            begin
                idle_reg <= 1'b1;
            end
            else
            begin
                ran_id_reg <= last.job_id;
                if (job_done)
                begin
                    finished_reg   <= 1'b1;
                    turnaround_reg <= pss_pkg::OUT_TIME_W'(ta_full);
                    waiting_reg    <= pss_pkg::OUT_TIME_W'(wt_full);
                end
            end
        end
    end

    assign res_valid  = res_valid_reg;
    assign ran_id     = ran_id_reg;
    assign idle       = idle_reg;
    assign finished   = finished_reg;
    assign turnaround = turnaround_reg;
    assign waiting    = waiting_reg;
    assign rejected   = rejected_reg;

    // running job always sits in an occupied slot between items
    a_running_occupied: assert property (@(posedge clk) disable iff (!rst_n)
        (running_valid_reg && state_reg == S_IDLE) |-> occ[running_slot_reg])
        else $error("running job slot is empty");

    // the fetch walk of a tick returns the running slot
    a_fetch_hits: assert property (@(posedge clk) disable iff (!rst_n)
        (in_exec && tick_reg && running_valid_reg)
            |-> (last.found && last_slot == running_slot_reg))
        else $error("scan chain lost the running job");

    // a result carries at most one of idle, finished and rejected
    a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> $onehot0({idle_reg, finished_reg, rejected_reg}))
        else $error("result flags conflict");

endmodule

// ===== tb/preemptive_priority_scheduler_core_tb.sv =====
// self-checking testbench for the preemptive priority scheduler core
// drives arrival and tick items, predicts every result and compares it field by field
// depends on pss_pkg and preemptive_priority_scheduler_core
`timescale 1ns / 1ps

module preemptive_priority_scheduler_core_tb;

    localparam int NSLOT          = pss_pkg::SLOTS_DEF;
    localparam int RAND_ITEMS     = 850;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    // item kinds
    localparam logic CMD_ARRIVE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // one result item as the block reports it
    typedef struct packed {
        logic [pss_pkg::ID_W-1:0]       ran_id;
        logic                           idle;
        logic                           finished;
        logic [pss_pkg::OUT_TIME_W-1:0] turnaround;
        logic [pss_pkg::OUT_TIME_W-1:0] waiting;
        logic                           rejected;
    } sched_res_t;

    // one row of the directed table; reps repeats the row with rising ids
    typedef struct {
        logic                        cmd;
        logic [pss_pkg::ID_W-1:0]    id;
        logic [pss_pkg::BURST_W-1:0] burst;
        logic [pss_pkg::PRIO_W-1:0]  prio;
        int                          reps;
        bit                          typed;
        sched_res_t                  res;
    } stim_row_t;

    localparam sched_res_t RES_NONE = '0;
    localparam sched_res_t RES_IDLE = '{ran_id: '0, idle: 1'b1, finished: 1'b0,
                                        turnaround: '0, waiting: '0, rejected: 1'b0};
    localparam sched_res_t RES_REJECT = '{ran_id: '0, idle: 1'b0, finished: 1'b0,
                                          turnaround: '0, waiting: '0, rejected: 1'b1};
    // single unit job of id 63 stamped at 1, finished at 2
    localparam sched_res_t RES_ID63_DONE = '{ran_id: 6'd63, idle: 1'b0, finished: 1'b1,
                                             turnaround: 16'd1, waiting: 16'd0,
                                             rejected: 1'b0};
    // zero burst job of id 0 stamped at 2, finished at 3, waits its whole turnaround
    localparam sched_res_t RES_ZERO_DONE = '{ran_id: 6'd0, idle: 1'b0, finished: 1'b1,
                                             turnaround: 16'd1, waiting: 16'd1,
                                             rejected: 1'b0};

    logic                              clk            = 1'b0;
    logic                              rst_n          = 1'b0;
    logic                              cmd_valid      = 1'b0;
    logic                              cmd_stall;
    logic                              command        = CMD_TICK;
    logic [pss_pkg::ID_W-1:0]          proc_id        = '0;
    logic [pss_pkg::BURST_W-1:0]       burst_length   = '0;
    logic [pss_pkg::PRIO_W-1:0]        priority_level = '0;
    logic                              res_valid;
    logic                              res_stall      = 1'b0;
    logic [pss_pkg::ID_W-1:0]          ran_id;
    logic                              idle;
    logic                              finished;
    logic [pss_pkg::OUT_TIME_W-1:0]    turnaround;
    logic [pss_pkg::OUT_TIME_W-1:0]    waiting;
    logic                              rejected;

    // typed expectation that travels with the item on the bus
    bit                                drv_typed      = 1'b0;
    sched_res_t                        drv_tres       = RES_NONE;

    int                                send_idle_pct  = 0;
    int                                recv_stall_pct = 0;
    int                                errors         = 0;
    int                                quiet_cycles   = 0;
    sched_res_t                        pending_results[$];

    // shadow job table of the predictor
    bit                                tbl_used  [NSLOT] = '{default: 1'b0};
    logic [pss_pkg::ID_W-1:0]          tbl_id    [NSLOT] = '{default: '0};
    logic [pss_pkg::BURST_W-1:0]       tbl_left  [NSLOT] = '{default: '0};
    logic [pss_pkg::BURST_W-1:0]       tbl_burst [NSLOT] = '{default: '0};
    logic [pss_pkg::PRIO_W-1:0]        tbl_prio  [NSLOT] = '{default: '0};
    logic [15:0]                       tbl_stamp [NSLOT] = '{default: '0};
    bit                                tbl_ran   [NSLOT] = '{default: 1'b0};
    logic [15:0]                       clock_now = '0;
    int                                cur_slot  = 0;
    bit                                cur_valid = 1'b0;

    // extremes, both item kinds, preemption, duplicate ids, zero burst and a full table
    stim_row_t dir_tab [15] = '{
        '{CMD_TICK,   6'd0,  8'd0,   8'd0,   1,  1'b1, RES_IDLE},
        '{CMD_ARRIVE, 6'd63, 8'd1,   8'd255, 1,  1'b0, RES_NONE},
        '{CMD_TICK,   6'd0,  8'd0,   8'd0,   1,  1'b1, RES_ID63_DONE},
        '{CMD_ARRIVE, 6'd0,  8'd0,   8'd0,   1,  1'b0, RES_NONE},
        '{CMD_TICK,   6'd0,  8'd0,   8'd0,   1,  1'b1, RES_ZERO_DONE},
        '{CMD_ARRIVE, 6'd5,  8'd255, 8'd100, 1,  1'b0, RES_NONE},
        '{CMD_TICK,   6'd0,  8'd0,   8'd0,   1,  1'b0, RES_NONE},
        '{CMD_ARRIVE, 6'd7,  8'd2,   8'd100, 1,  1'b0, RES_NONE},
        '{CMD_ARRIVE, 6'd9,  8'd2,   8'd50,  1,  1'b0, RES_NONE},
        '{CMD_TICK,   6'd0,  8'd0,   8'd0,   1,  1'b0, RES_NONE},
        '{CMD_ARRIVE, 6'd9,  8'd1,   8'd50,  1,  1'b0, RES_NONE},
        '{CMD_TICK,   6'd0,  8'd0,   8'd0,   1,  1'b0, RES_NONE},
        '{CMD_TICK,   6'd0,  8'd0,   8'd0,   1,  1'b0, RES_NONE},
        '{CMD_ARRIVE, 6'd16, 8'd3,   8'd200, 14, 1'b0, RES_NONE},
        '{CMD_ARRIVE, 6'd1,  8'd1,   8'd0,   1,  1'b1, RES_REJECT}
    };

    preemptive_priority_scheduler_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd_stall      (cmd_stall),
        .command        (command),
        .proc_id        (proc_id),
        .burst_length   (burst_length),
        .priority_level (priority_level),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .ran_id         (ran_id),
        .idle           (idle),
        .finished       (finished),
        .turnaround     (turnaround),
        .waiting        (waiting),
        .rejected       (rejected)
    );

    always #5 clk = ~clk;

    // dispatch order: priority, not yet run, oldest stamp, lower id, lower slot
    function automatic bit outranks(input int a, input int b);
        logic [15:0] age_a;
        logic [15:0] age_b;
        age_a = clock_now - tbl_stamp[a];
        age_b = clock_now - tbl_stamp[b];
        if (tbl_prio[a] != tbl_prio[b])
            return tbl_prio[a] < tbl_prio[b];
        if (tbl_ran[a] != tbl_ran[b])
            return !tbl_ran[a];
        if (age_a != age_b)
            return age_a > age_b;
        if (tbl_id[a] != tbl_id[b])
            return tbl_id[a] < tbl_id[b];
        return a < b;
    endfunction

    // advance the shadow scheduler by one item; returns 1 when a result is due
    function automatic bit schedule_item(input logic cmd,
                                         input logic [pss_pkg::ID_W-1:0] id,
                                         input logic [pss_pkg::BURST_W-1:0] burst,
                                         input logic [pss_pkg::PRIO_W-1:0] prio,
                                         output sched_res_t res);
        int          s;
        bit          hit;
        logic [15:0] ta;
        res = RES_NONE;
        s   = 0;
        hit = 1'b0;
        if (cmd == CMD_ARRIVE)
        begin
            // lowest free slot, or refuse when the table is full
            for (int i = 0; i < NSLOT; i++)
            begin
                if (!hit && !tbl_used[i])
                begin
                    s   = i;
                    hit = 1'b1;
                end
            end
            if (!hit)
            begin
                res.rejected = 1'b1;
                return 1'b1;
            end
            tbl_used[s]  = 1'b1;
            tbl_id[s]    = id;
            tbl_left[s]  = burst;
            tbl_burst[s] = burst;
            tbl_prio[s]  = prio;
            tbl_stamp[s] = clock_now;
            tbl_ran[s]   = 1'b0;
            // strictly more urgent arrival takes over the running job
            if (cur_valid && prio < tbl_prio[cur_slot])
            begin
                tbl_ran[cur_slot] = 1'b1;
                cur_slot          = s;
            end
            return 1'b0;
        end
        // dispatch when nothing is running
        if (!cur_valid || !tbl_used[cur_slot])
        begin
            cur_valid = 1'b0;
            for (int i = 0; i < NSLOT; i++)
            begin
                if (tbl_used[i] && (!hit || outranks(i, s)))
                begin
                    s   = i;
                    hit = 1'b1;
                end
            end
            if (hit)
            begin
                cur_slot  = s;
                cur_valid = 1'b1;
            end
        end
        clock_now = clock_now + 16'd1;
        if (!cur_valid)
        begin
            res.idle = 1'b1;
            return 1'b1;
        end
        // run one unit, zero burst counts as one
        s          = cur_slot;
        res.ran_id = tbl_id[s];
        tbl_ran[s] = 1'b1;
        if (tbl_left[s] <= 8'd1)
        begin
            tbl_left[s]    = '0;
            ta             = clock_now - tbl_stamp[s];
            res.finished   = 1'b1;
            res.turnaround = ta;
            res.waiting    = ta - {8'd0, tbl_burst[s]};
            tbl_used[s]    = 1'b0;
            cur_valid      = 1'b0;
        end
        else
        begin
            tbl_left[s] = tbl_left[s] - 8'd1;
        end
        return 1'b1;
    endfunction

    // present one item at the falling edge after a random gap, hold it until taken
    task automatic send_item(input logic cmd,
                             input logic [pss_pkg::ID_W-1:0] id,
                             input logic [pss_pkg::BURST_W-1:0] burst,
                             input logic [pss_pkg::PRIO_W-1:0] prio,
                             input bit typed,
                             input sched_res_t tres);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        @(negedge clk);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid      <= 1'b1;
        command        <= cmd;
        proc_id        <= id;
        burst_length   <= burst;
        priority_level <= prio;
        drv_typed      <= typed;
        drv_tres       <= tres;
        do
            @(posedge clk);
        while (cmd_stall);
    endtask

    // sender holds off until every outstanding result has come back
    task automatic drain_results();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // receiver back-pressure
    always @(negedge clk)
        res_stall <= ($urandom_range(0, 99) < recv_stall_pct);

    // result check, then prediction for an item taken at the same edge
    always @(posedge clk)
    begin : monitor
        sched_res_t got;
        sched_res_t want;
        sched_res_t pred;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                got = '{ran_id: ran_id, idle: idle, finished: finished,
                        turnaround: turnaround, waiting: waiting, rejected: rejected};
                if (pending_results.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: result with none expected: ran_id=%0d idle=%0d",
                                 $realtime, got.ran_id, got.idle);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                        begin
                            $display("%0t: mismatch exp id=%0d idle=%0d fin=%0d ta=%0d wt=%0d rej=%0d",
                                     $realtime, want.ran_id, want.idle, want.finished,
                                     want.turnaround, want.waiting, want.rejected);
                            $display("%0t:          got id=%0d idle=%0d fin=%0d ta=%0d wt=%0d rej=%0d",
                                     $realtime, got.ran_id, got.idle, got.finished,
                                     got.turnaround, got.waiting, got.rejected);
                        end
                    end
                end
            end
            if (cmd_valid && !cmd_stall)
            begin
                if (schedule_item(command, proc_id, burst_length, priority_level, pred))
                    pending_results.insert(pending_results.size(),
                                           drv_typed ? drv_tres : pred);
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // reset, directed table, then three phases of random items
    initial
    begin : stimulus
        int                          arrive_pct;
        int                          roll;
        logic                        cmd;
        logic [pss_pkg::ID_W-1:0]    id;
        logic [pss_pkg::BURST_W-1:0] burst;
        logic [pss_pkg::PRIO_W-1:0]  prio;
        send_idle_pct  = 21;
        recv_stall_pct = 47;
        arrive_pct     = 40;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // directed part
        foreach (dir_tab[r])
        begin
            for (int k = 0; k < dir_tab[r].reps; k++)
                send_item(dir_tab[r].cmd, dir_tab[r].id + 6'(k), dir_tab[r].burst,
                          dir_tab[r].prio, dir_tab[r].typed, dir_tab[r].res);
        end
        drain_results();

        // random part; arrival mix changes every fifty items so the table fills and drains
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n == RAND_ITEMS / 3)
            begin
                drain_results();
                send_idle_pct  = 47;
                recv_stall_pct = 21;
            end
            else if (n == 2 * RAND_ITEMS / 3)
            begin
                drain_results();
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            if (n % 50 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       arrive_pct = 20;
                    1:       arrive_pct = 45;
                    default: arrive_pct = 75;
                endcase
            end
            cmd = ($urandom_range(0, 99) < arrive_pct) ? CMD_ARRIVE : CMD_TICK;
            // a few ids so duplicates are common
            id = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 3))
                                             : 6'($urandom_range(0, 63));
            // mostly short jobs, rare zero and long bursts
            roll = $urandom_range(0, 99);
            if (roll < 3)
                burst = 8'd0;
            else if (roll < 75)
                burst = 8'($urandom_range(1, 4));
            else if (roll < 95)
                burst = 8'($urandom_range(5, 20));
            else
                burst = 8'($urandom_range(21, 255));
            // narrow band of priorities for ties
            prio = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3))
                                               : 8'($urandom_range(0, 255));
            send_item(cmd, id, burst, prio, 1'b0, RES_NONE);
        end
        drain_results();
        repeat (3 * (NSLOT + 2)) @(posedge clk);

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
